/* hdl/pec_pkg.sv */
package pec_pkg;

  localparam int unsigned PRE_MAX_DEF   = 32;
  localparam int unsigned ALARM_LEN_DEF = 64;

  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned COUNT_W    = RING_AW + 1;

  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned STAMP_W  = 48;
  localparam int unsigned INTVL_W  = 32;
  localparam int unsigned PREMIN_W = 6;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_MIN      = 1'd1;

  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_ALARM   = 1'b1;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                compressed_ok;
    logic                event_flag;
    logic [STAMP_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [HANDLE_W-1:0] out_handle;
    logic [STAMP_W-1:0]  alarm_stamp;
    logic                last_of_alarm;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENTER,
    S_CHECK,
    S_POP_RD,
    S_POP_OUT,
    S_TRIG,
    S_RUN_RD,
    S_RUN_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic enter;
    logic rd_head;
    logic pop_out;
    logic set_capture;
    logic run_start;
    logic run_out;
  } dp_cmd_t;

  typedef struct packed {
    logic ok;
    logic capturing;
    logic out_free;
    logic over_pre;
    logic run_full;
    logic trig_ok;
    logic run_last;
  } dp_status_t;

endpackage

/* hdl/pec_ctrl.sv */
module pec_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_valid,
  output logic                frame_stall,
  input  pec_pkg::dp_status_t status,
  output pec_pkg::dp_cmd_t    cmd
);
  import pec_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (frame_valid) state_next = S_ENTER;
      end
      S_ENTER: begin
        if (status.ok || status.out_free) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.capturing) begin
          state_next = status.run_full ? S_RUN_RD : S_IDLE;
        end else if (!status.ok) begin
          state_next = S_IDLE;
        end else begin
          state_next = status.over_pre ? S_POP_RD : S_TRIG;
        end
      end
      S_POP_RD:  state_next = S_POP_OUT;
      S_POP_OUT: begin
        if (status.out_free) state_next = S_TRIG;
      end
      S_TRIG:    state_next = S_IDLE;
      S_RUN_RD:  state_next = S_RUN_OUT;
      S_RUN_OUT: begin
        if (status.out_free && status.run_last) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    frame_stall = (state != S_IDLE);
    case (state)
      S_IDLE:    cmd.load_item = frame_valid;
      // good frames push at once, failed ones wait for the output register
      S_ENTER:   cmd.enter = status.ok || status.out_free;
      S_CHECK:   cmd.run_start = status.capturing && status.run_full;
      S_POP_RD:  cmd.rd_head = 1'b1;
      S_POP_OUT: cmd.pop_out = status.out_free;
      S_TRIG:    cmd.set_capture = status.trig_ok;
      S_RUN_RD:  cmd.rd_head = 1'b1;
      S_RUN_OUT: cmd.run_out = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

/* hdl/pec_datapath.sv */
module pec_datapath #(
  parameter int unsigned PRE_MAX   = pec_pkg::PRE_MAX_DEF,
  parameter int unsigned ALARM_LEN = pec_pkg::ALARM_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pec_pkg::in_item_t                   frame,
  output pec_pkg::out_item_t                  result,
  output logic                                result_valid,
  input  logic                                result_stall,
  input  logic                                cfg_valid,
  input  logic [pec_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pec_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  pec_pkg::dp_cmd_t                    cmd,
  output pec_pkg::dp_status_t                 status
);
  import pec_pkg::*;

  logic [HANDLE_W-1:0] ring [RING_DEPTH];
  logic [HANDLE_W-1:0] rd_data;
  logic [RING_AW-1:0]  rd_addr;
  logic                rd_en;
  logic [RING_AW-1:0]  wr_addr;
  logic                wr_en;

  in_item_t            item;
  logic [RING_AW-1:0]  head;
  logic [RING_AW-1:0]  head_inc;
  logic [COUNT_W-1:0]  count;
  logic                capturing;
  logic [STAMP_W-1:0]  last_alarm_time;
  logic [INTVL_W-1:0]  min_interval;
  logic [PREMIN_W-1:0] pre_min;
  logic [STAMP_W-1:0]  elapsed;
  logic                time_ok;
  logic                emit;
  logic                run_last;

  assign head_inc = head + RING_AW'(1);
  assign wr_addr  = head + count[RING_AW-1:0];
  assign wr_en    = cmd.enter && item.compressed_ok && (count < COUNT_W'(RING_DEPTH));
  assign run_last = (count == COUNT_W'(1));
  assign rd_en    = cmd.rd_head || (cmd.run_out && !run_last);
  // during readout the next entry is fetched while the current one goes out
  assign rd_addr  = cmd.rd_head ? head : head_inc;

  // a timestamp going backwards counts as no time elapsed
  assign elapsed = item.now_ms - last_alarm_time;
  assign time_ok = (item.now_ms > last_alarm_time) &&
                   (elapsed > {{(STAMP_W-INTVL_W){1'b0}}, min_interval});

  assign emit = (cmd.enter && !item.compressed_ok) || cmd.pop_out || cmd.run_out;

  always_comb begin
    status.ok        = item.compressed_ok;
    status.capturing = capturing;
    status.out_free  = !result_valid || !result_stall;
    status.over_pre  = count > COUNT_W'(PRE_MAX);
    status.run_full  = count >= COUNT_W'(ALARM_LEN);
    status.trig_ok   = item.event_flag && (count > {1'b0, pre_min}) && time_ok;
    status.run_last  = run_last;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= item.handle;
    end
    if (rd_en) begin
      rd_data <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= frame;
    end
    if (cmd.enter && !item.compressed_ok) begin
      result.kind          <= KIND_RELEASE;
      result.out_handle    <= item.handle;
      result.alarm_stamp   <= '0;
      result.last_of_alarm <= 1'b0;
    end else if (cmd.pop_out) begin
      result.kind          <= KIND_RELEASE;
      result.out_handle    <= rd_data;
      result.alarm_stamp   <= '0;
      result.last_of_alarm <= 1'b0;
    end else if (cmd.run_out) begin
      result.kind          <= KIND_ALARM;
      result.out_handle    <= rd_data;
      result.alarm_stamp   <= last_alarm_time;
      result.last_of_alarm <= run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head            <= '0;
      count           <= '0;
      capturing       <= 1'b0;
      last_alarm_time <= '0;
      result_valid    <= 1'b0;
      min_interval    <= '0;
      pre_min         <= PREMIN_W'(8);
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      if (wr_en) begin
        count <= count + COUNT_W'(1);
      end else if (cmd.pop_out) begin
        head  <= head_inc;
        count <= count - COUNT_W'(1);
      end else if (cmd.run_out) begin
        if (run_last) begin
          head      <= '0;
          count     <= '0;
          capturing <= 1'b0;
        end else begin
          head  <= head_inc;
          count <= count - COUNT_W'(1);
        end
      end

      if (cmd.set_capture) begin
        capturing <= 1'b1;
      end
      if (cmd.run_start) begin
        last_alarm_time <= item.now_ms;
      end

      if (cfg_valid) begin
        case (cfg_index)
          REG_MIN_INTERVAL: min_interval <= cfg_data[INTVL_W-1:0];
          REG_PRE_MIN:      pre_min      <= cfg_data[PREMIN_W-1:0];
          default:          ;
        endcase
      end
    end
  end

endmodule

/* hdl/pretrigger_event_capture.sv */
// channel  | signals                              | direction
// frame    | frame_valid, frame_stall, frame      | frame reports in
// result   | result_valid, result_stall, result   | released and alarm handles out
// cfg      | cfg_valid, cfg_ready, cfg_index/data | register writes in, always ready
//
// an idle good frame steps through accept, push, check and trigger test; a failed
// frame or a frame during capture skips the trigger test; an overflow release adds the ring read
// and an output step; a frame that completes an alarm run adds a first memory read, then
// outputs each handle, later reads overlapping the output
// the result register is the only stall point; a stalled result holds the sequencer
// synchronous reset empties the ring (count and head) and clears the alarm time
module pretrigger_event_capture #(
  parameter int unsigned PRE_MAX   = pec_pkg::PRE_MAX_DEF,
  parameter int unsigned ALARM_LEN = pec_pkg::ALARM_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            frame_valid,
  output logic                            frame_stall,
  input  pec_pkg::in_item_t               frame,
  output logic                            result_valid,
  input  logic                            result_stall,
  output pec_pkg::out_item_t              result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pec_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pec_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  pec_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .status      (status),
    .cmd         (cmd)
  );

  pec_datapath #(
    .PRE_MAX   (PRE_MAX),
    .ALARM_LEN (ALARM_LEN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

/* sim/capture_checker.sv */
`timescale 1ns / 1ps

module capture_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           frame_valid,
  input  logic                           frame_stall,
  input  pec_pkg::in_item_t              frame,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  pec_pkg::out_item_t             result,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pec_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             outstanding
);
  import pec_pkg::*;

  localparam int unsigned PRE_LIMIT     = PRE_MAX_DEF;
  localparam int unsigned RUN_LEN       = ALARM_LEN_DEF;
  localparam int unsigned PRE_MIN_RESET = 8;

  logic [HANDLE_W-1:0] ring_mem [RING_DEPTH];
  logic [RING_AW-1:0]  ring_head;
  logic [COUNT_W-1:0]  ring_count;
  logic                capturing;
  logic [STAMP_W-1:0]  last_alarm;
  logic [INTVL_W-1:0]  min_interval;
  logic [PREMIN_W-1:0] pre_min;

  out_item_t handles_due [$];

  task automatic queue_result(input out_item_t r);
    handles_due.insert(handles_due.size(), r);
  endtask

  task automatic ring_store(input logic [HANDLE_W-1:0] h);
    if (ring_count < RING_DEPTH) begin
      ring_mem[ring_head + ring_count[RING_AW-1:0]] = h;
      ring_count = ring_count + 1'b1;
    end
  endtask

  function automatic logic [HANDLE_W-1:0] take_oldest();
    logic [HANDLE_W-1:0] h;
    h = ring_mem[ring_head];
    ring_head = ring_head + 1'b1;
    ring_count = ring_count - 1'b1;
    return h;
  endfunction

  // works out the releases and alarm handles caused by one frame report
  task automatic capture_frame(input in_item_t f);
    out_item_t r;
    r = '0;
    if (!f.compressed_ok) begin
      r.kind = KIND_RELEASE;
      r.out_handle = f.handle;
      queue_result(r);
    end
    if (capturing) begin
      if (f.compressed_ok) ring_store(f.handle);
      if (ring_count >= RUN_LEN) begin
        last_alarm = f.now_ms;
        while (ring_count != 0) begin
          r.kind = KIND_ALARM;
          r.out_handle = take_oldest();
          r.alarm_stamp = f.now_ms;
          r.last_of_alarm = (ring_count == 0);
          queue_result(r);
        end
        ring_head = '0;
        capturing = 1'b0;
      end
    end else if (f.compressed_ok) begin
      ring_store(f.handle);
      if (ring_count > PRE_LIMIT) begin
        r = '0;
        r.kind = KIND_RELEASE;
        r.out_handle = take_oldest();
        queue_result(r);
      end
      // a timestamp that went backwards counts as no elapsed time
      if (f.event_flag && ring_count > pre_min && f.now_ms > last_alarm &&
          (f.now_ms - last_alarm) > {{(STAMP_W-INTVL_W){1'b0}}, min_interval})
        capturing = 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    logic      bad;
    if (rst) begin
      ring_head = '0;
      ring_count = '0;
      capturing = 1'b0;
      last_alarm = '0;
      min_interval = '0;
      pre_min = PRE_MIN_RESET;
      handles_due.delete();
      errors = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (handles_due.size() == 0) begin
          $display("%0t: unexpected result kind %0d handle %h stamp %h last %0b",
                   $time, result.kind, result.out_handle, result.alarm_stamp,
                   result.last_of_alarm);
          errors++;
        end else begin
          want = handles_due.pop_front();
          bad = 1'b0;
          if (result.kind !== want.kind) begin
            $display("%0t: kind expected %0d got %0d", $time, want.kind, result.kind);
            bad = 1'b1;
          end
          if (result.out_handle !== want.out_handle) begin
            $display("%0t: out_handle expected %h got %h", $time, want.out_handle,
                     result.out_handle);
            bad = 1'b1;
          end
          if (result.alarm_stamp !== want.alarm_stamp) begin
            $display("%0t: alarm_stamp expected %h got %h", $time, want.alarm_stamp,
                     result.alarm_stamp);
            bad = 1'b1;
          end
          if (result.last_of_alarm !== want.last_of_alarm) begin
            $display("%0t: last_of_alarm expected %0b got %0b", $time,
                     want.last_of_alarm, result.last_of_alarm);
            bad = 1'b1;
          end
          if (bad) errors++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_INTERVAL: min_interval = cfg_data[INTVL_W-1:0];
          REG_PRE_MIN: pre_min = cfg_data[PREMIN_W-1:0];
          default: ;
        endcase
      end
      if (frame_valid && !frame_stall) capture_frame(frame);
    end
    outstanding = handles_due.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import pec_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  frame_valid;
  logic                  frame_stall;
  in_item_t              frame;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_item_t             result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // frame clock in ms, kept wide so increments saturate instead of wrapping
  logic [63:0] clock_ms;

  always #5 clk = ~clk;

  pretrigger_event_capture dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  capture_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic in_item_t make_frame(input logic [HANDLE_W-1:0] h, input logic ok,
                                          input logic ev, input logic [STAMP_W-1:0] t);
    in_item_t f;
    f.handle = h;
    f.compressed_ok = ok;
    f.event_flag = ev;
    f.now_ms = t;
    return f;
  endfunction

  function automatic in_item_t random_frame();
    in_item_t    f;
    int unsigned pick;
    logic [63:0] r;
    pick = $urandom_range(0, 119);
    f.handle = 16'($urandom_range(0, 16'hFFFF));
    f.compressed_ok = ($urandom_range(0, 99) < 92);
    f.event_flag = ($urandom_range(0, 99) < 10);
    if (pick < 2) begin
      // one-off stamp from the past, the clock itself does not move
      r = {$urandom, $urandom};
      f.now_ms = 48'(r % (clock_ms + 64'd1));
    end else begin
      if (pick < 4)
        clock_ms = clock_ms + {31'd0, 1'($urandom_range(0, 1)), 32'($urandom)};
      else if (pick < 90)
        clock_ms = clock_ms + 64'($urandom_range(0, 600));
      if (clock_ms > 64'hFFFF_FFFF_FFFF) clock_ms = 64'hFFFF_FFFF_FFFF;
      f.now_ms = clock_ms[STAMP_W-1:0];
    end
    return f;
  endfunction

  task automatic send_frame(input in_item_t f);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      frame_valid <= 1'b0;
      @(negedge clk);
    end
    frame_valid <= 1'b1;
    frame <= f;
    do @(posedge clk); while (frame_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain all pending results, then give a silent frame time to finish
  task automatic settle();
    @(negedge clk);
    frame_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic run_phase(input logic [INTVL_W-1:0] interval,
                           input logic [PREMIN_W-1:0] pmin,
                           input int send_pct, input int recv_pct, input int n);
    settle();
    recv_stall_pct = 0;
    write_reg(REG_MIN_INTERVAL, interval);
    // upper data bits are don't-care for the 6-bit register
    write_reg(REG_PRE_MIN, {26'($urandom_range(0, 32'h03FF_FFFF)), pmin});
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) send_frame(random_frame());
  endtask

  initial begin
    int wait_cycles;
    rst = 1'b1;
    frame_valid = 1'b0;
    frame = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    clock_ms = 64'h0000_FF00_0000_0000;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed part at reset settings: trigger needs more than 8 handles
    send_frame(make_frame(16'h0000, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF));
    // failed frame with event while idle: release only
    send_frame(make_frame(16'hFFFF, 1'b0, 1'b1, 48'h0));
    send_frame(make_frame(16'hFFFF, 1'b1, 1'b0, 48'h0));
    // no elapsed time since last alarm stamp of zero, so no trigger yet
    for (int i = 3; i <= 9; i++)
      send_frame(make_frame(16'h0100 + 16'(i), 1'b1, (i >= 8), 48'h0));
    send_frame(make_frame(16'h5A5A, 1'b1, 1'b1, 48'h1));
    // event during capture is ignored, failed frame still released
    send_frame(make_frame(16'hA5A5, 1'b1, 1'b1, 48'h2));
    send_frame(make_frame(16'h1234, 1'b0, 1'b0, 48'h3));

    run_phase(32'd0, 6'd8, 0, 0, 100);
    run_phase(32'd500, 6'd0, 83, 0, 90);
    run_phase(32'hFFFF_FFFF, 6'd31, 0, 83, 90);
    run_phase(32'd250, 6'd32, 34, 34, 80);
    run_phase(32'd50, 6'd63, 0, 0, 40);
    run_phase(32'd0, 6'd1, 34, 34, 50);

    @(negedge clk);
    frame_valid <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 200000 && outstanding != 0; wait_cycles++)
      @(negedge clk);
    repeat (20) @(negedge clk);
    if (outstanding != 0)
      $display("%0t: %0d expected results never arrived", $time, outstanding);
    if (errors == 0 && outstanding == 0)
      $display("pretrigger_event_capture test passed");
    else
      $display("pretrigger_event_capture test failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("pretrigger_event_capture test failed");
    $finish;
  end

endmodule

/* pretrigger_event_capture.f */
hdl/pec_pkg.sv
hdl/pec_ctrl.sv
hdl/pec_datapath.sv
hdl/pretrigger_event_capture.sv
sim/capture_checker.sv
sim/tb_top.sv
